// File: rtl/thbg_pkg.sv
// ----------------------------------------------------------------------------
// thbg_pkg
// Types and constants shared by the trilinear hexahedral basis pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package thbg_pkg;

   localparam logic signed [16:0] ONE_Q14     = 17'sd16384;
   localparam logic signed [51:0] BASIS_HALF  = 52'sd268435456;
   localparam logic signed [50:0] GRAD_HALF   = 51'sd1073741824;
   localparam logic        [16:0] BASIS_MAX   = 17'd65536;
   localparam logic        [2:0]  LAST_NODE   = 3'd7;
   localparam logic        [31:0] GRAD_POS_MAX = 32'h7fff_ffff;
   localparam logic        [31:0] GRAD_NEG_MAX = 32'h8000_0000;

   typedef logic signed [31:0] word_type;
   typedef word_type [2:0][2:0] jac_type;
   typedef logic signed [16:0] fac_type;
   typedef logic signed [33:0] pair_type;
   typedef logic signed [50:0] cube_type;
   typedef logic signed [49:0] hprod_type;
   typedef logic signed [48:0] lprod_type;
   typedef logic signed [51:0] hsum_type;
   typedef logic signed [50:0] lsum_type;

   typedef struct packed {
      logic [2:0] node;
      logic       px;
      logic       py;
      logic       pz;
      fac_type    fx;
      fac_type    fy;
      fac_type    fz;
      jac_type    jac;
   } s1_type;

   typedef struct packed {
      logic [2:0] node;
      logic       px;
      logic       py;
      logic       pz;
      fac_type    fx;
      pair_type   pyz;
      pair_type   pxz;
      pair_type   pxy;
      jac_type    jac;
   } s2_type;

   typedef struct packed {
      logic [2:0]     node;
      pair_type [2:0] d;
      cube_type       p;
      jac_type        jac;
   } s3_type;

   typedef struct packed {
      logic [2:0]            node;
      logic [16:0]           basis;
      hprod_type [2:0][2:0]  hp;
      lprod_type [2:0][2:0]  lp;
   } s4_type;

   typedef struct packed {
      logic [2:0]     node;
      logic [16:0]    basis;
      hsum_type [2:0] hi;
      lsum_type [2:0] lo;
   } s5_type;

   typedef struct packed {
      logic valid;
   } link_type;

endpackage

`default_nettype wire

// File: rtl/thbg_node_seq.sv
// ----------------------------------------------------------------------------
// thbg_node_seq
// Holds one item and issues its eight corner nodes, one per cycle unless stalled,
// forming the factors (1 +- t) for each node into the first pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module thbg_node_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic signed [15:0] ref_x,
   input  wire logic signed [15:0] ref_y,
   input  wire logic signed [15:0] ref_z,
   input  wire thbg_pkg::jac_type  inv_jac,
   input  wire logic               down_ready,
   output      thbg_pkg::link_type s1_link,
   output      thbg_pkg::s1_type   s1_data
);

   logic signed [15:0] x_ff, y_ff, z_ff;
   thbg_pkg::jac_type  jac_ff;
   logic               busy_ff, busy_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   thbg_pkg::s1_type   s1_ff, s1_in;
   logic               s1_ready;
   logic               issue;
   logic               accept;
   logic               px, py, pz;

   assign s1_ready  = !s1_valid_ff || down_ready;
   assign issue     = busy_ff && s1_ready;
   assign req_stall = busy_ff && !(issue && (cnt_ff == thbg_pkg::LAST_NODE));
   assign accept    = req_valid && !req_stall;

   // node sign pattern
   assign px = cnt_ff[0] ^ cnt_ff[1];
   assign py = cnt_ff[1];
   assign pz = cnt_ff[2];

   always_comb begin
      s1_in.node = cnt_ff;
      s1_in.px   = px;
      s1_in.py   = py;
      s1_in.pz   = pz;
      s1_in.fx   = px ? thbg_pkg::ONE_Q14 + 17'(x_ff) : thbg_pkg::ONE_Q14 - 17'(x_ff);
      s1_in.fy   = py ? thbg_pkg::ONE_Q14 + 17'(y_ff) : thbg_pkg::ONE_Q14 - 17'(y_ff);
      s1_in.fz   = pz ? thbg_pkg::ONE_Q14 + 17'(z_ff) : thbg_pkg::ONE_Q14 - 17'(z_ff);
      s1_in.jac  = jac_ff;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (issue) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == thbg_pkg::LAST_NODE) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end

      s1_valid_in = s1_ready ? busy_ff : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= 3'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= ref_x;
         y_ff   <= ref_y;
         z_ff   <= ref_z;
         jac_ff <= inv_jac;
      end
      if (issue) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_link.valid = s1_valid_ff;
   assign s1_data       = s1_ff;

endmodule

`default_nettype wire

// File: rtl/thbg_factor_mul.sv
// ----------------------------------------------------------------------------
// thbg_factor_mul
// Two stages: pairwise factor products, then the signed reference gradient
// and the full basis product.
// ----------------------------------------------------------------------------
`default_nettype none

module thbg_factor_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output      logic               up_ready,
   input  wire thbg_pkg::s1_type   s1_data,
   input  wire logic               down_ready,
   output      thbg_pkg::link_type s3_link,
   output      thbg_pkg::s3_type   s3_data
);

   logic             s2_valid_ff, s2_valid_in;
   logic             s3_valid_ff, s3_valid_in;
   thbg_pkg::s2_type s2_ff, s2_in;
   thbg_pkg::s3_type s3_ff, s3_in;
   logic             s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || down_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign up_ready = s2_ready;

   always_comb begin
      s2_in.node = s1_data.node;
      s2_in.px   = s1_data.px;
      s2_in.py   = s1_data.py;
      s2_in.pz   = s1_data.pz;
      s2_in.fx   = s1_data.fx;
      s2_in.pyz  = $signed(s1_data.fy) * $signed(s1_data.fz);
      s2_in.pxz  = $signed(s1_data.fx) * $signed(s1_data.fz);
      s2_in.pxy  = $signed(s1_data.fx) * $signed(s1_data.fy);
      s2_in.jac  = s1_data.jac;

      s3_in.node = s2_ff.node;
      s3_in.d[0] = s2_ff.px ? s2_ff.pyz : -s2_ff.pyz;
      s3_in.d[1] = s2_ff.py ? s2_ff.pxz : -s2_ff.pxz;
      s3_in.d[2] = s2_ff.pz ? s2_ff.pxy : -s2_ff.pxy;
      s3_in.p    = $signed(s2_ff.fx) * $signed(s2_ff.pyz);
      s3_in.jac  = s2_ff.jac;

      s2_valid_in = s2_ready ? up_valid : s2_valid_ff;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && up_valid) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign s3_link.valid = s3_valid_ff;
   assign s3_data       = s3_ff;

endmodule

`default_nettype wire

// File: rtl/thbg_grad_mul.sv
// ----------------------------------------------------------------------------
// thbg_grad_mul
// Two stages: split partial products of the inverse Jacobian with the
// reference gradient plus basis rounding, then the per-row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module thbg_grad_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output      logic               up_ready,
   input  wire thbg_pkg::s3_type   s3_data,
   input  wire logic               down_ready,
   output      thbg_pkg::link_type s5_link,
   output      thbg_pkg::s5_type   s5_data
);

   logic               s4_valid_ff, s4_valid_in;
   logic               s5_valid_ff, s5_valid_in;
   thbg_pkg::s4_type   s4_ff, s4_in;
   thbg_pkg::s5_type   s5_ff, s5_in;
   logic               s4_ready, s5_ready;
   logic signed [51:0] bsum;
   logic signed [22:0] bq;

   assign s5_ready = !s5_valid_ff || down_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign up_ready = s4_ready;

   always_comb begin
      s4_in.node = s3_data.node;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s4_in.hp[r][c] = $signed(s3_data.jac[r][c]) * $signed(s3_data.d[c][33:16]);
            s4_in.lp[r][c] = $signed(s3_data.jac[r][c]) * $signed({1'b0, s3_data.d[c][15:0]});
         end
      end

      // round to nearest, clamp to 0 .. 1.0
      bsum = thbg_pkg::hsum_type'($signed(s3_data.p)) + thbg_pkg::BASIS_HALF;
      bq   = $signed(bsum[51:29]);
      if (bq[22]) begin
         s4_in.basis = 17'd0;
      end else if (bq[21:0] > 22'(thbg_pkg::BASIS_MAX)) begin
         s4_in.basis = thbg_pkg::BASIS_MAX;
      end else begin
         s4_in.basis = bq[16:0];
      end

      s5_in.node  = s4_ff.node;
      s5_in.basis = s4_ff.basis;
      for (int r = 0; r < 3; r++) begin
         s5_in.hi[r] = thbg_pkg::hsum_type'($signed(s4_ff.hp[r][0]))
                     + thbg_pkg::hsum_type'($signed(s4_ff.hp[r][1]))
                     + thbg_pkg::hsum_type'($signed(s4_ff.hp[r][2]));
         s5_in.lo[r] = thbg_pkg::lsum_type'($signed(s4_ff.lp[r][0]))
                     + thbg_pkg::lsum_type'($signed(s4_ff.lp[r][1]))
                     + thbg_pkg::lsum_type'($signed(s4_ff.lp[r][2]))
                     + thbg_pkg::GRAD_HALF;
      end

      s4_valid_in = s4_ready ? up_valid : s4_valid_ff;
      s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && up_valid) begin
         s4_ff <= s4_in;
      end
      if (s5_ready && s4_valid_ff) begin
         s5_ff <= s5_in;
      end
   end

   assign s5_link.valid = s5_valid_ff;
   assign s5_data       = s5_ff;

endmodule

`default_nettype wire

// File: rtl/thbg_result.sv
// ----------------------------------------------------------------------------
// thbg_result
// Output register: merges the split row sums, rounds and saturates each
// gradient component, and presents one result item per node.
// ----------------------------------------------------------------------------
`default_nettype none

module thbg_result (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output      logic               up_ready,
   input  wire thbg_pkg::s5_type   s5_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [2:0]         rsp_node,
   output      logic [16:0]        rsp_basis_value,
   output      logic signed [31:0] rsp_grad_x,
   output      logic signed [31:0] rsp_grad_y,
   output      logic signed [31:0] rsp_grad_z,
   output      logic               rsp_last
);

   logic               valid_ff, valid_in;
   logic [2:0]         node_ff;
   logic [16:0]        basis_ff;
   logic [2:0][31:0]   grad_ff, grad_in;
   logic               load;
   logic signed [52:0] merged [3];
   logic signed [37:0] rq [3];

   assign up_ready = !valid_ff || !rsp_stall;
   assign load     = up_ready && up_valid;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         merged[r] = 53'(s5_data.hi[r]) + 53'($signed(s5_data.lo[r][50:16]));
         rq[r]     = $signed(merged[r][52:15]);
         if (rq[r][37:31] == {7{rq[r][31]}}) begin
            grad_in[r] = rq[r][31:0];
         end else if (rq[r][37]) begin
            grad_in[r] = thbg_pkg::GRAD_NEG_MAX;
         end else begin
            grad_in[r] = thbg_pkg::GRAD_POS_MAX;
         end
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         node_ff  <= s5_data.node;
         basis_ff <= s5_data.basis;
         grad_ff  <= grad_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_node        = node_ff;
   assign rsp_basis_value = basis_ff;
   assign rsp_grad_x      = grad_ff[0];
   assign rsp_grad_y      = grad_ff[1];
   assign rsp_grad_z      = grad_ff[2];
   assign rsp_last        = (node_ff == thbg_pkg::LAST_NODE);

endmodule

`default_nettype wire

// File: rtl/trilinear_hex_basis_gradient_top.sv
// ----------------------------------------------------------------------------
// path: each node result passes the s1, s2, s3, s4, s5 and output registers
// throughput: one node result per cycle unless stalled; the node sequencer issues
// the eight corners of an item in turn and takes a new item as it issues node 7
// reset: synchronous, clears every valid bit and the sequencer, no storage
// ----------------------------------------------------------------------------
// trilinear_hex_basis_gradient_top
// Q1 hexahedral shape functions and physical gradients for eight corners.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_hex_basis_gradient_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic signed [15:0] req_ref_x,
   input  wire logic signed [15:0] req_ref_y,
   input  wire logic signed [15:0] req_ref_z,
   input  wire logic signed [31:0] req_inv_jac_00,
   input  wire logic signed [31:0] req_inv_jac_01,
   input  wire logic signed [31:0] req_inv_jac_02,
   input  wire logic signed [31:0] req_inv_jac_10,
   input  wire logic signed [31:0] req_inv_jac_11,
   input  wire logic signed [31:0] req_inv_jac_12,
   input  wire logic signed [31:0] req_inv_jac_20,
   input  wire logic signed [31:0] req_inv_jac_21,
   input  wire logic signed [31:0] req_inv_jac_22,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [2:0]         rsp_node,
   output      logic [16:0]        rsp_basis_value,
   output      logic signed [31:0] rsp_grad_x,
   output      logic signed [31:0] rsp_grad_y,
   output      logic signed [31:0] rsp_grad_z,
   output      logic               rsp_last
);

   thbg_pkg::jac_type  inv_jac;
   thbg_pkg::link_type s1_link, s3_link, s5_link;
   thbg_pkg::s1_type   s1_data;
   thbg_pkg::s3_type   s3_data;
   thbg_pkg::s5_type   s5_data;
   logic               fm_ready, gm_ready, res_ready;

   always_comb begin
      inv_jac[0][0] = req_inv_jac_00;
      inv_jac[0][1] = req_inv_jac_01;
      inv_jac[0][2] = req_inv_jac_02;
      inv_jac[1][0] = req_inv_jac_10;
      inv_jac[1][1] = req_inv_jac_11;
      inv_jac[1][2] = req_inv_jac_12;
      inv_jac[2][0] = req_inv_jac_20;
      inv_jac[2][1] = req_inv_jac_21;
      inv_jac[2][2] = req_inv_jac_22;
   end

   thbg_node_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .ref_x      (req_ref_x),
      .ref_y      (req_ref_y),
      .ref_z      (req_ref_z),
      .inv_jac    (inv_jac),
      .down_ready (fm_ready),
      .s1_link    (s1_link),
      .s1_data    (s1_data)
   );

   thbg_factor_mul u_fmul (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (s1_link.valid),
      .up_ready   (fm_ready),
      .s1_data    (s1_data),
      .down_ready (gm_ready),
      .s3_link    (s3_link),
      .s3_data    (s3_data)
   );

   thbg_grad_mul u_gmul (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (s3_link.valid),
      .up_ready   (gm_ready),
      .s3_data    (s3_data),
      .down_ready (res_ready),
      .s5_link    (s5_link),
      .s5_data    (s5_data)
   );

   thbg_result u_res (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (s5_link.valid),
      .up_ready        (res_ready),
      .s5_data         (s5_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node        (rsp_node),
      .rsp_basis_value (rsp_basis_value),
      .rsp_grad_x      (rsp_grad_x),
      .rsp_grad_y      (rsp_grad_y),
      .rsp_grad_z      (rsp_grad_z),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: verif/trilinear_hex_basis_gradient_top_test.sv
// ----------------------------------------------------------------------------
// trilinear_hex_basis_gradient_top_test
// Self-checking bench for the Q1 hexahedral shape function pipeline. Each
// reference point and inverse Jacobian sent in is expanded into its eight
// corner results, and each result that arrives is checked field by field.
// Directed points cover the cube corners and centre, points outside the cube,
// basis clamping, gradient saturation and rounding. Random points follow,
// under bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_hex_basis_gradient_top_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic signed [15:0] ref_x;
      logic signed [15:0] ref_y;
      logic signed [15:0] ref_z;
      thbg_pkg::jac_type  jac;
   } point_item_type;

   typedef struct {
      logic [2:0]         node;
      logic [16:0]        basis;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic signed [31:0] gz;
      logic               last;
   } corner_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_ref_x = '0;
   logic signed [15:0] req_ref_y = '0;
   logic signed [15:0] req_ref_z = '0;
   logic signed [31:0] req_inv_jac_00 = '0;
   logic signed [31:0] req_inv_jac_01 = '0;
   logic signed [31:0] req_inv_jac_02 = '0;
   logic signed [31:0] req_inv_jac_10 = '0;
   logic signed [31:0] req_inv_jac_11 = '0;
   logic signed [31:0] req_inv_jac_12 = '0;
   logic signed [31:0] req_inv_jac_20 = '0;
   logic signed [31:0] req_inv_jac_21 = '0;
   logic signed [31:0] req_inv_jac_22 = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_node;
   logic [16:0]        rsp_basis_value;
   logic signed [31:0] rsp_grad_x;
   logic signed [31:0] rsp_grad_y;
   logic signed [31:0] rsp_grad_z;
   logic               rsp_last;

   corner_result_type expected_corners[$];
   int                fail_count = 0;
   int                cycle_count = 0;

   int          burst_left = 0;
   int          gap_max = 0;
   int          burst_max = 1;
   int          stall_percent = 0;
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_phase = '0;

   trilinear_hex_basis_gradient_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ref_x      (req_ref_x),
      .req_ref_y      (req_ref_y),
      .req_ref_z      (req_ref_z),
      .req_inv_jac_00 (req_inv_jac_00),
      .req_inv_jac_01 (req_inv_jac_01),
      .req_inv_jac_02 (req_inv_jac_02),
      .req_inv_jac_10 (req_inv_jac_10),
      .req_inv_jac_11 (req_inv_jac_11),
      .req_inv_jac_12 (req_inv_jac_12),
      .req_inv_jac_20 (req_inv_jac_20),
      .req_inv_jac_21 (req_inv_jac_21),
      .req_inv_jac_22 (req_inv_jac_22),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_node       (rsp_node),
      .rsp_basis_value(rsp_basis_value),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_grad_z     (rsp_grad_z),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** trilinear_hex_basis_gradient_top: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      stall_phase <= stall_phase + 4'd1;
      rsp_stall <= stall_pattern[stall_phase] || ($urandom_range(99) < stall_percent);
   end

   task automatic report_error(input string msg);
      $display("error at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // exact sum of jac * dref, rounded half up, scaled by 2^-31, saturated
   function automatic logic signed [31:0] gradient_component(
      input thbg_pkg::word_type j0, input thbg_pkg::word_type j1,
      input thbg_pkg::word_type j2,
      input longint d0, input longint d1, input longint d2);
      longint jv[3];
      longint dv[3];
      longint hi;
      longint lo;
      longint dh;
      longint r;
      jv[0] = j0; jv[1] = j1; jv[2] = j2;
      dv[0] = d0; dv[1] = d1; dv[2] = d2;
      hi = 0;
      lo = 0;
      for (int c = 0; c < 3; c++) begin
         dh = dv[c] >>> 16;
         hi += jv[c] * dh;
         lo += jv[c] * (dv[c] - dh * 65536);
      end
      lo += 64'sd1073741824;
      r = (hi + (lo >>> 16)) >>> 15;
      if (r > 64'sd2147483647)
         r = 64'sd2147483647;
      if (r < -64'sd2147483648)
         r = -64'sd2147483648;
      return r[31:0];
   endfunction

   task automatic predict_corners(input point_item_type it);
      longint            x, y, z, fx, fy, fz, p, b, d0, d1, d2;
      bit                px, py, pz;
      corner_result_type res;
      x = it.ref_x;
      y = it.ref_y;
      z = it.ref_z;
      for (int n = 0; n < 8; n++) begin
         px = (n == 1 || n == 2 || n == 5 || n == 6);
         py = (n == 2 || n == 3 || n == 6 || n == 7);
         pz = (n >= 4);
         fx = px ? 16384 + x : 16384 - x;
         fy = py ? 16384 + y : 16384 - y;
         fz = pz ? 16384 + z : 16384 - z;
         p = fx * fy * fz;
         b = (p + 64'sd268435456) >>> 29;
         if (b < 0)
            b = 0;
         if (b > 65536)
            b = 65536;
         d0 = px ? fy * fz : -(fy * fz);
         d1 = py ? fx * fz : -(fx * fz);
         d2 = pz ? fx * fy : -(fx * fy);
         res.node = n[2:0];
         res.basis = b[16:0];
         res.gx = gradient_component(it.jac[0][0], it.jac[0][1], it.jac[0][2], d0, d1, d2);
         res.gy = gradient_component(it.jac[1][0], it.jac[1][1], it.jac[1][2], d0, d1, d2);
         res.gz = gradient_component(it.jac[2][0], it.jac[2][1], it.jac[2][2], d0, d1, d2);
         res.last = (n == 7);
         expected_corners.push_back(res);
      end
   endtask

   always @(posedge clock) begin : corner_checker
      corner_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_corners.size() == 0) begin
            report_error($sformatf("unexpected item for node %0d", rsp_node));
         end else begin
            want = expected_corners.pop_front();
            check_field("node", rsp_node, want.node);
            check_field($sformatf("node %0d basis", want.node), rsp_basis_value, want.basis);
            check_field($sformatf("node %0d grad_x", want.node), rsp_grad_x, want.gx);
            check_field($sformatf("node %0d grad_y", want.node), rsp_grad_y, want.gy);
            check_field($sformatf("node %0d grad_z", want.node), rsp_grad_z, want.gz);
            check_field($sformatf("node %0d last", want.node), rsp_last, want.last);
         end
      end
   end

   task automatic set_traffic(input int gaps, input int bursts, input int stall_pct,
                              input logic [15:0] pattern);
      gap_max = gaps;
      burst_max = bursts;
      stall_percent = stall_pct;
      stall_pattern = pattern;
      burst_left = 0;
   endtask

   task automatic send_point(input point_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(gap_max, 0);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(burst_max, 1);
      end
      @(negedge clock);
      req_ref_x <= it.ref_x;
      req_ref_y <= it.ref_y;
      req_ref_z <= it.ref_z;
      req_inv_jac_00 <= it.jac[0][0];
      req_inv_jac_01 <= it.jac[0][1];
      req_inv_jac_02 <= it.jac[0][2];
      req_inv_jac_10 <= it.jac[1][0];
      req_inv_jac_11 <= it.jac[1][1];
      req_inv_jac_12 <= it.jac[1][2];
      req_inv_jac_20 <= it.jac[2][0];
      req_inv_jac_21 <= it.jac[2][1];
      req_inv_jac_22 <= it.jac[2][2];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_corners(it);
      burst_left--;
   endtask

   function automatic thbg_pkg::jac_type make_jacobian(input thbg_pkg::word_type diag,
                                                       input thbg_pkg::word_type off);
      thbg_pkg::jac_type j;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            j[r][c] = (r == c) ? diag : off;
      return j;
   endfunction

   function automatic thbg_pkg::jac_type random_jacobian(input int max_shift);
      thbg_pkg::jac_type j;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            j[r][c] = $signed($urandom) >>> $urandom_range(max_shift, 0);
      return j;
   endfunction

   function automatic point_item_type make_point(input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z,
                                                 input thbg_pkg::jac_type j);
      point_item_type it;
      it.ref_x = x;
      it.ref_y = y;
      it.ref_z = z;
      it.jac = j;
      return it;
   endfunction

   function automatic logic signed [15:0] coord_in_cube();
      return 16'($signed(int'($urandom_range(32768, 0))) - 16384);
   endfunction

   function automatic logic signed [15:0] coord_edge();
      case ($urandom_range(5, 0))
         0: return -16'sd16384;
         1: return 16'sd16384;
         2: return 16'sd0;
         3: return 16'sh8000;
         4: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_cube_corners();
      thbg_pkg::jac_type ident;
      ident = make_jacobian(32'sd65536, 32'sd0);
      send_point(make_point(16'sd0, 16'sd0, 16'sd0, ident));
      for (int n = 0; n < 8; n++)
         send_point(make_point(
            (n == 1 || n == 2 || n == 5 || n == 6) ? 16'sd16384 : -16'sd16384,
            (n == 2 || n == 3 || n == 6 || n == 7) ? 16'sd16384 : -16'sd16384,
            (n >= 4) ? 16'sd16384 : -16'sd16384,
            make_jacobian(32'sd65536, 32'sd4096)));
   endtask

   task automatic test_outside_cube();
      thbg_pkg::jac_type ident;
      ident = make_jacobian(32'sd65536, 32'sd0);
      // basis clamps at zero and at one
      send_point(make_point(16'sh7fff, 16'sd0, 16'sd0, ident));
      send_point(make_point(16'sh8000, 16'sh8000, 16'sh8000, ident));
      send_point(make_point(16'sh7fff, 16'sh7fff, 16'sh7fff, ident));
      send_point(make_point(16'sh7fff, 16'sh8000, 16'sd20000, ident));
   endtask

   task automatic test_gradient_saturation();
      send_point(make_point(16'sh8000, 16'sh8000, 16'sh8000,
                            make_jacobian(32'sh7fffffff, 32'sh7fffffff)));
      send_point(make_point(16'sh8000, 16'sh8000, 16'sh8000,
                            make_jacobian(32'sh80000000, 32'sh80000000)));
      send_point(make_point(16'sh7fff, 16'sh7fff, 16'sh8000,
                            make_jacobian(32'sh7fffffff, 32'sh80000000)));
      send_point(make_point(16'sd16384, 16'sd16384, 16'sd16384,
                            make_jacobian(32'sh80000000, 32'sh7fffffff)));
   endtask

   task automatic test_rounding_edges();
      send_point(make_point(16'sd1, -16'sd1, 16'sd0, make_jacobian(32'sd1, -32'sd1)));
      send_point(make_point(-16'sd1, 16'sd8192, -16'sd8192, make_jacobian(32'sd0, 32'sd0)));
      send_point(make_point(16'sd3, 16'sd5, -16'sd7, make_jacobian(-32'sd1, 32'sd3)));
      send_point(make_point(16'shffff, 16'sd0, 16'sd1, make_jacobian(32'shffffffff, 32'sd1)));
   endtask

   task automatic test_random_in_cube(input int count);
      for (int i = 0; i < count; i++)
         send_point(make_point(coord_in_cube(), coord_in_cube(), coord_in_cube(),
                               random_jacobian(20)));
   endtask

   task automatic test_random_full_range(input int count);
      for (int i = 0; i < count; i++)
         send_point(make_point(16'($urandom), 16'($urandom), 16'($urandom),
                               random_jacobian(($urandom_range(1, 0) == 1) ? 0 : 24)));
   endtask

   task automatic test_random_edge_mix(input int count);
      for (int i = 0; i < count; i++)
         send_point(make_point(coord_edge(), coord_edge(), coord_edge(),
                               random_jacobian(31)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_traffic(0, 1, 0, 16'h0000);
      test_cube_corners();
      set_traffic(3, 4, 30, 16'h0000);
      test_outside_cube();
      test_gradient_saturation();
      set_traffic(0, 1, 0, 16'h0f0f);
      test_rounding_edges();

      set_traffic(0, 1, 0, 16'h0000);
      test_random_in_cube(80);
      set_traffic(12, 6, 20, 16'h8001);
      test_random_in_cube(90);
      set_traffic(4, 10, 60, 16'h3c00);
      test_random_full_range(90);
      set_traffic(0, 1, 0, 16'h0000);
      test_random_full_range(60);
      set_traffic(8, 3, 10, 16'haaaa);
      test_random_edge_mix(70);
      set_traffic(2, 20, 45, 16'h0000);
      test_random_in_cube(60);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_corners.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** trilinear_hex_basis_gradient_top: PASSED **");
      else
         $display("** trilinear_hex_basis_gradient_top: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/thbg_pkg.sv
rtl/thbg_node_seq.sv
rtl/thbg_factor_mul.sv
rtl/thbg_grad_mul.sv
rtl/thbg_result.sv
rtl/trilinear_hex_basis_gradient_top.sv
verif/trilinear_hex_basis_gradient_top_test.sv
